FILE: hw/rtl/cbc_pkg.sv
package cbc_pkg;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_SELECT   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO_THRESHOLD  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSOLUTE_MINIMUM = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_RUN      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_COUNT    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MARK_ENABLE      = 4'd7;

  // Channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CSUM_W  = 10;
  localparam int RATIO_W = 9;
  localparam int RUN_W   = 10;
  localparam int COUNT_W = 24;
  localparam int SUM_W   = 36;
  localparam int POS_W   = 12;
  localparam int BOX_W   = 13;

  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int QUEUE_DEPTH    = 4;

  typedef struct packed {
    logic [1:0]         channel_select;
    logic [RATIO_W-1:0] ratio_threshold;
    logic [CSUM_W-1:0]  absolute_minimum;
    logic [RUN_W-1:0]   minimum_run;
    logic [COUNT_W-1:0] minimum_count;
    logic [BOX_W-1:0]   frame_width;
    logic [BOX_W-1:0]   frame_height;
    logic               mark_enable;
  } cfg_t;

  // Word from the front part to the back part
  typedef struct packed {
    logic               marked;
    logic               frame_done;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COUNT_W-1:0] pixel_count;
    logic [BOX_W-1:0]   box_min_x;
    logic [POS_W-1:0]   box_max_x;
    logic [BOX_W-1:0]   box_min_y;
    logic [POS_W-1:0]   box_max_y;
    logic               target_found;
  } word_t;

  typedef struct packed {
    logic               marked;
    logic               frame_done;
    logic [POS_W-1:0]   centroid_x;
    logic [POS_W-1:0]   centroid_y;
    logic [COUNT_W-1:0] pixel_count;
    logic [BOX_W-1:0]   box_min_x;
    logic [POS_W-1:0]   box_max_x;
    logic [BOX_W-1:0]   box_min_y;
    logic [POS_W-1:0]   box_max_y;
    logic               target_found;
  } result_t;

endpackage

FILE: hw/rtl/cbc_front.sv
module cbc_front import cbc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  input  logic             end_of_line,
  input  logic             end_of_frame,
  input  cfg_t             cfg,
  output word_t            word
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  logic               frame_start;
  logic [COL_W-1:0]   column, column_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [RUN_W-1:0]   run_length, run_length_next;
  logic [COUNT_W-1:0] counted, counted_next;
  logic [SUM_W-1:0]   sum_x, sum_x_next, sum_y, sum_y_next;
  logic [BOX_W-1:0]   least_x, least_x_next, least_y, least_y_next;
  logic [POS_W-1:0]   greatest_x, greatest_x_next, greatest_y, greatest_y_next;

  // State as seen by this pixel (frame start loads the initial values)
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [RUN_W-1:0]   cur_run;
  logic [COUNT_W-1:0] cur_cnt;
  logic [SUM_W-1:0]   cur_sx, cur_sy;
  logic [BOX_W-1:0]   cur_lx, cur_ly;
  logic [POS_W-1:0]   cur_gx, cur_gy;

  logic [CSUM_W-1:0]  csum, den;
  logic [PIX_W-1:0]   chan;
  logic [18:0]        lhs, rhs;
  logic               qualifies, hit;
  logic [POS_W-1:0]   col_pos, row_pos;

  always_comb begin
    cur_col = frame_start ? '0 : column;
    cur_row = frame_start ? '0 : row;
    cur_run = frame_start ? '0 : run_length;
    cur_cnt = frame_start ? '0 : counted;
    cur_sx  = frame_start ? '0 : sum_x;
    cur_sy  = frame_start ? '0 : sum_y;
    cur_lx  = frame_start ? cfg.frame_width : least_x;
    cur_ly  = frame_start ? cfg.frame_height : least_y;
    cur_gx  = frame_start ? '0 : greatest_x;
    cur_gy  = frame_start ? '0 : greatest_y;
  end

  always_comb begin
    unique case (cfg.channel_select)
      CH_BLUE:  chan = blue;
      CH_GREEN: chan = green;
      default:  chan = red;
    endcase
  end

  assign csum = CSUM_W'(blue) + CSUM_W'(green) + CSUM_W'(red);
  assign den  = (csum == '0) ? CSUM_W'(1) : csum;
  assign lhs  = 19'({chan, 8'h00});
  assign rhs  = 19'(cfg.ratio_threshold) * 19'(den);
  assign qualifies = (lhs >= rhs) && (CSUM_W'(chan) >= cfg.absolute_minimum)
                  && (csum >= cfg.absolute_minimum);
  assign hit = qualifies && (cur_run >= cfg.minimum_run) && (cur_cnt != COUNT_MAX);

  assign col_pos = POS_W'(cur_col);
  assign row_pos = POS_W'(cur_row);

  always_comb begin
    counted_next    = cur_cnt;
    sum_x_next      = cur_sx;
    sum_y_next      = cur_sy;
    least_x_next    = cur_lx;
    least_y_next    = cur_ly;
    greatest_x_next = cur_gx;
    greatest_y_next = cur_gy;
    if (hit) begin
      counted_next = cur_cnt + COUNT_W'(1);
      sum_x_next   = cur_sx + SUM_W'(col_pos);
      sum_y_next   = cur_sy + SUM_W'(row_pos);
      if (BOX_W'(col_pos) < cur_lx) least_x_next = BOX_W'(col_pos);
      if (col_pos > cur_gx) greatest_x_next = col_pos;
      if (BOX_W'(row_pos) < cur_ly) least_y_next = BOX_W'(row_pos);
      if (row_pos > cur_gy) greatest_y_next = row_pos;
    end

    if (!qualifies) run_length_next = '0;
    else if (cur_run != RUN_MAX) run_length_next = cur_run + RUN_W'(1);
    else run_length_next = cur_run;

    column_next = cur_col;
    row_next    = cur_row;
    if (end_of_line && !end_of_frame) begin
      column_next = '0;
      if (cur_row != ROW_LAST) row_next = cur_row + ROW_W'(1);
    end else if (!end_of_frame) begin
      if (cur_col != COL_LAST) column_next = cur_col + COL_W'(1);
    end
  end

  // Summary fields ride only on the frame's last word
  always_comb begin
    word = '0;
    word.marked     = hit && cfg.mark_enable;
    word.frame_done = end_of_frame;
    if (end_of_frame) begin
      word.sum_x        = sum_x_next;
      word.sum_y        = sum_y_next;
      word.pixel_count  = counted_next;
      word.box_min_x    = least_x_next;
      word.box_max_x    = greatest_x_next;
      word.box_min_y    = least_y_next;
      word.box_max_y    = greatest_y_next;
      word.target_found = counted_next > cfg.minimum_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
      column      <= '0;
      row         <= '0;
      run_length  <= '0;
      counted     <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      least_x     <= '0;
      least_y     <= '0;
      greatest_x  <= '0;
      greatest_y  <= '0;
    end else if (accept) begin
      frame_start <= end_of_frame;
      column      <= column_next;
      row         <= row_next;
      run_length  <= run_length_next;
      counted     <= counted_next;
      sum_x       <= sum_x_next;
      sum_y       <= sum_y_next;
      least_x     <= least_x_next;
      least_y     <= least_y_next;
      greatest_x  <= greatest_x_next;
      greatest_y  <= greatest_y_next;
    end
  end

endmodule

FILE: hw/rtl/cbc_fifo.sv
module cbc_fifo import cbc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  word_t wr_word,
  output logic  full,
  input  logic  rd_en,
  output word_t rd_word,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  word_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr, do_rd;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) fill <= fill + CNT_W'(1);
      else if (do_rd && !do_wr) fill <= fill - CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/cbc_back.sv
module cbc_back import cbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  word_t   q_word,
  input  logic    q_empty,
  output logic    q_pop,
  output result_t res,
  output logic    res_valid,
  input  logic    res_pop
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic {S_FETCH, S_DIVIDE} state_t;

  state_t             state;
  word_t              hold;
  logic [SUM_W-1:0]   dvd_x, dvd_y;
  logic [COUNT_W-1:0] rem_x, rem_y;
  logic [POS_W-1:0]   quo_x, quo_y;
  logic [STEP_W-1:0]  step;
  logic               out_free;
  logic               res_load;
  result_t            plain_res;

  logic [COUNT_W:0]   trial_x, trial_y;
  logic               ge_x, ge_y;

  assign out_free = !res_valid || res_pop;
  assign q_pop    = (state == S_FETCH) && !q_empty && out_free;

  // Load the result register with a plain word or a finished frame word
  assign res_load = (q_pop && !q_word.frame_done)
                 || ((state == S_DIVIDE) && (step == '0) && out_free);

  // Plain words carry only the mark
  always_comb begin
    plain_res        = '0;
    plain_res.marked = q_word.marked;
  end

  // One restoring step for each coordinate
  assign trial_x = {rem_x, dvd_x[SUM_W-1]};
  assign trial_y = {rem_y, dvd_y[SUM_W-1]};
  assign ge_x    = trial_x >= {1'b0, hold.pixel_count};
  assign ge_y    = trial_y >= {1'b0, hold.pixel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      res_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
      unique case (state)
        S_FETCH: begin
          if (q_pop) begin
            if (q_word.frame_done) begin
              hold  <= q_word;
              dvd_x <= q_word.sum_x;
              dvd_y <= q_word.sum_y;
              rem_x <= '0;
              rem_y <= '0;
              step  <= STEP_W'(SUM_W);
              state <= S_DIVIDE;
            end else begin
              res <= plain_res;
            end
          end
        end
        S_DIVIDE: begin
          if (step != '0) begin
            rem_x <= COUNT_W'(ge_x ? trial_x - {1'b0, hold.pixel_count} : trial_x);
            rem_y <= COUNT_W'(ge_y ? trial_y - {1'b0, hold.pixel_count} : trial_y);
            quo_x <= {quo_x[POS_W-2:0], ge_x};
            quo_y <= {quo_y[POS_W-2:0], ge_y};
            dvd_x <= {dvd_x[SUM_W-2:0], 1'b0};
            dvd_y <= {dvd_y[SUM_W-2:0], 1'b0};
            step  <= step - STEP_W'(1);
          end else if (out_free) begin
            res.marked       <= hold.marked;
            res.frame_done   <= 1'b1;
            res.centroid_x   <= (hold.pixel_count == '0) ? '0 : quo_x;
            res.centroid_y   <= (hold.pixel_count == '0) ? '0 : quo_y;
            res.pixel_count  <= hold.pixel_count;
            res.box_min_x    <= hold.box_min_x;
            res.box_max_x    <= hold.box_max_x;
            res.box_min_y    <= hold.box_min_y;
            res.box_max_y    <= hold.box_max_y;
            res.target_found <= hold.target_found;
            state            <= S_FETCH;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

FILE: hw/rtl/color_blob_centroid_bbox.sv
// Color blob centroid and bounding box. Pixels come in raster order, blue,
// green and red with end-of-line and end-of-frame marks, and each accepted
// pixel yields exactly one result word: marked is set when the pixel was
// counted toward the blob and marking is enabled, and on the frame's last
// pixel frame_done is set together with the centroid, the pixel count, the
// bounding box and the found flag (all summary fields read zero on other
// words). The front part classifies and accumulates one pixel per clock
// while the queue has room and writes a word into a four-word queue; the
// back part loads ordinary words into the result register as it fetches
// them, so pixels stream at one per clock while results are popped. A
// frame-done word holds the back part while it is fetched, divided by a
// restoring divider that produces one quotient bit per cycle for x and y in
// parallel over the 36-bit sums, and loaded into the result register.
// During that time the queue absorbs four more pixels, after which full
// stays high until the back part fetches again. Configuration writes land in
// registers at once and the frame-sized settings take effect on the first
// pixel of the next frame; write them only while no word is in flight.
module color_blob_centroid_bbox import cbc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel queue side
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       blue,
  input  logic [PIX_W-1:0]       green,
  input  logic [PIX_W-1:0]       red,
  input  logic                   end_of_line,
  input  logic                   end_of_frame,
  // result queue side
  output logic                   empty,
  input  logic                   pop,
  output logic                   marked,
  output logic                   frame_done,
  output logic [POS_W-1:0]       centroid_x,
  output logic [POS_W-1:0]       centroid_y,
  output logic [COUNT_W-1:0]     pixel_count,
  output logic [BOX_W-1:0]       box_min_x,
  output logic [POS_W-1:0]       box_max_x,
  output logic [BOX_W-1:0]       box_min_y,
  output logic [POS_W-1:0]       box_max_y,
  output logic                   target_found,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  word_t   front_word, q_word;
  logic    accept, q_empty, q_pop, res_valid;
  result_t res;

  // Hold the register file; drop writes beyond the last index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_select   <= CH_RED;
      cfg.ratio_threshold  <= RATIO_W'(128);
      cfg.absolute_minimum <= CSUM_W'(100);
      cfg.minimum_run      <= RUN_W'(25);
      cfg.minimum_count    <= COUNT_W'(350);
      cfg.frame_width      <= BOX_W'(640);
      cfg.frame_height     <= BOX_W'(480);
      cfg.mark_enable      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_SELECT:   cfg.channel_select   <= 2'(cfg_data);
        REG_RATIO_THRESHOLD:  cfg.ratio_threshold  <= RATIO_W'(cfg_data);
        REG_ABSOLUTE_MINIMUM: cfg.absolute_minimum <= CSUM_W'(cfg_data);
        REG_MINIMUM_RUN:      cfg.minimum_run      <= RUN_W'(cfg_data);
        REG_MINIMUM_COUNT:    cfg.minimum_count    <= COUNT_W'(cfg_data);
        REG_FRAME_WIDTH:      cfg.frame_width      <= BOX_W'(cfg_data);
        REG_FRAME_HEIGHT:     cfg.frame_height     <= BOX_W'(cfg_data);
        REG_MARK_ENABLE:      cfg.mark_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A pixel word enters when the queue has room
  assign accept = push && !full;

  cbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .cfg          (cfg),
    .word         (front_word)
  );

  cbc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_word (front_word),
    .full    (full),
    .rd_en   (q_pop),
    .rd_word (q_word),
    .empty   (q_empty)
  );

  cbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_word    (q_word),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty        = !res_valid;
  assign marked       = res.marked;
  assign frame_done   = res.frame_done;
  assign centroid_x   = res.centroid_x;
  assign centroid_y   = res.centroid_y;
  assign pixel_count  = res.pixel_count;
  assign box_min_x    = res.box_min_x;
  assign box_max_x    = res.box_max_x;
  assign box_min_y    = res.box_min_y;
  assign box_max_y    = res.box_max_y;
  assign target_found = res.target_found;

endmodule

FILE: hw/rtl/cbc_checker.sv
module cbc_checker import cbc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   empty,
  input logic                   pop,
  input logic                   marked,
  input logic                   frame_done,
  input logic [POS_W-1:0]       centroid_x,
  input logic [POS_W-1:0]       centroid_y,
  input logic [COUNT_W-1:0]     pixel_count,
  input logic [BOX_W-1:0]       box_min_x,
  input logic [POS_W-1:0]       box_max_x,
  input logic [BOX_W-1:0]       box_min_y,
  input logic [POS_W-1:0]       box_max_y,
  input logic                   target_found
);

  // No result is shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // Summary fields are zero on words that do not end a frame
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_done) |-> (pixel_count == '0 && centroid_x == '0 &&
      centroid_y == '0 && box_min_x == '0 && box_max_x == '0 &&
      box_min_y == '0 && box_max_y == '0 && !target_found))
    else $error("summary field set on a plain word");

  // An empty frame reports a zero centroid and no target
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done && pixel_count == '0) |->
      (centroid_x == '0 && centroid_y == '0 && !target_found))
    else $error("empty frame with centroid or target");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_done) && $stable(marked) &&
      $stable(centroid_x) && $stable(centroid_y) && $stable(pixel_count)))
    else $error("waiting result changed");

endmodule

bind color_blob_centroid_bbox cbc_checker u_cbc_checker (.*);

FILE: tb/tb.sv
module tb;
  import cbc_pkg::*;

  // Channel code 3 is unused by the block and must behave like red
  localparam logic [1:0] CH_SPARE = 2'd3;

  localparam int RANDOM_PIXELS = 1650;
  localparam int LONG_RUN      = 1040;  // past the 1023 run counter ceiling
  localparam int HOLD_CYCLES   = 400;   // long receiver stall
  localparam int DRAIN_CYCLES  = 48;    // room for a frame-done division to finish
  localparam int REPORT_LIMIT  = 60;

  // Scoreboard: mirrors the blob accumulator and keeps the result words
  // still owed by the block, oldest first.
  class blob_scoreboard;
    cfg_t               cfg;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [RUN_W-1:0]   run_length;
    logic [COUNT_W-1:0] counted;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [BOX_W-1:0]   least_x;
    logic [BOX_W-1:0]   least_y;
    logic [POS_W-1:0]   greatest_x;
    logic [POS_W-1:0]   greatest_y;
    bit                 frame_start;
    result_t            owed_words[$];
    int                 errors;

    function new();
      cfg.channel_select   = CH_RED;
      cfg.ratio_threshold  = 128;
      cfg.absolute_minimum = 100;
      cfg.minimum_run      = 25;
      cfg.minimum_count    = 350;
      cfg.frame_width      = 640;
      cfg.frame_height     = 480;
      cfg.mark_enable      = 1'b1;
      frame_start          = 1'b1;
      errors               = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CHANNEL_SELECT:   cfg.channel_select   = data[1:0];
        REG_RATIO_THRESHOLD:  cfg.ratio_threshold  = data[RATIO_W-1:0];
        REG_ABSOLUTE_MINIMUM: cfg.absolute_minimum = data[CSUM_W-1:0];
        REG_MINIMUM_RUN:      cfg.minimum_run      = data[RUN_W-1:0];
        REG_MINIMUM_COUNT:    cfg.minimum_count    = data[COUNT_W-1:0];
        REG_FRAME_WIDTH:      cfg.frame_width      = data[BOX_W-1:0];
        REG_FRAME_HEIGHT:     cfg.frame_height     = data[BOX_W-1:0];
        REG_MARK_ENABLE:      cfg.mark_enable      = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r, logic eol, logic eof);
      logic [CSUM_W-1:0] total;
      logic [PIX_W-1:0]  chan;
      int unsigned       den;
      bit                pass;
      bit                hit;
      result_t           w;
      if (frame_start) begin
        column      = '0;
        row         = '0;
        run_length  = '0;
        counted     = '0;
        sum_x       = '0;
        sum_y       = '0;
        least_x     = cfg.frame_width;
        least_y     = cfg.frame_height;
        greatest_x  = '0;
        greatest_y  = '0;
        frame_start = 1'b0;
      end
      total = CSUM_W'(b) + CSUM_W'(g) + CSUM_W'(r);
      case (cfg.channel_select)
        CH_BLUE:  chan = b;
        CH_GREEN: chan = g;
        default:  chan = r;
      endcase
      den  = (total == 0) ? 1 : int'(total);
      pass = (int'(chan) * 256 >= int'(cfg.ratio_threshold) * den) &&
             (CSUM_W'(chan) >= cfg.absolute_minimum) && (total >= cfg.absolute_minimum);
      hit  = pass && (run_length >= cfg.minimum_run) && (counted != COUNT_MAX);
      if (hit) begin
        counted = counted + 1'b1;
        sum_x   = sum_x + SUM_W'(column);
        sum_y   = sum_y + SUM_W'(row);
        if (BOX_W'(column) < least_x) least_x = BOX_W'(column);
        if (column > greatest_x)      greatest_x = column;
        if (BOX_W'(row) < least_y)    least_y = BOX_W'(row);
        if (row > greatest_y)         greatest_y = row;
      end
      // run length saturates rather than wrapping
      if (!pass)                   run_length = '0;
      else if (run_length != RUN_MAX) run_length = run_length + 1'b1;

      w = '0;
      w.marked = hit && cfg.mark_enable;
      if (eof) begin
        w.frame_done = 1'b1;
        if (counted != 0) begin
          w.centroid_x = POS_W'(sum_x / SUM_W'(counted));
          w.centroid_y = POS_W'(sum_y / SUM_W'(counted));
        end
        w.pixel_count  = counted;
        w.box_min_x    = least_x;
        w.box_max_x    = greatest_x;
        w.box_min_y    = least_y;
        w.box_max_y    = greatest_y;
        w.target_found = counted > cfg.minimum_count;
        frame_start    = 1'b1;
      end else if (eol) begin
        column = '0;
        if (row != POS_W'(MAX_HEIGHT_DEF - 1)) row = row + 1'b1;
      end else if (column != POS_W'(MAX_WIDTH_DEF - 1)) begin
        column = column + 1'b1;
      end
      owed_words.insert(owed_words.size(), w);
    endfunction

    function void match(string field, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (owed_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      want = owed_words.pop_front();
      match("marked",       want.marked,       got.marked);
      match("frame_done",   want.frame_done,   got.frame_done);
      match("centroid_x",   want.centroid_x,   got.centroid_x);
      match("centroid_y",   want.centroid_y,   got.centroid_y);
      match("pixel_count",  want.pixel_count,  got.pixel_count);
      match("box_min_x",    want.box_min_x,    got.box_min_x);
      match("box_max_x",    want.box_max_x,    got.box_max_x);
      match("box_min_y",    want.box_min_y,    got.box_min_y);
      match("box_max_y",    want.box_max_y,    got.box_max_y);
      match("target_found", want.target_found, got.target_found);
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             push = 1'b0;
  logic             full;
  logic [PIX_W-1:0] blue = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] red = '0;
  logic             end_of_line = 1'b0;
  logic             end_of_frame = 1'b0;

  logic               empty;
  logic               pop = 1'b0;
  logic               marked;
  logic               frame_done;
  logic [POS_W-1:0]   centroid_x;
  logic [POS_W-1:0]   centroid_y;
  logic [COUNT_W-1:0] pixel_count;
  logic [BOX_W-1:0]   box_min_x;
  logic [POS_W-1:0]   box_max_x;
  logic [BOX_W-1:0]   box_min_y;
  logic [POS_W-1:0]   box_max_y;
  logic               target_found;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  blob_scoreboard sb = new();

  int pixels_sent = 0;
  bit tx_burst = 1'b0;      // sender offers back to back
  bit rx_burst = 1'b0;      // receiver pops back to back
  bit hold_request = 1'b0;  // ask the receiver for one long stall

  color_blob_centroid_bbox uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .empty        (empty),
    .pop          (pop),
    .marked       (marked),
    .frame_done   (frame_done),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .pixel_count  (pixel_count),
    .box_min_x    (box_min_x),
    .box_max_x    (box_max_x),
    .box_min_y    (box_min_y),
    .box_max_y    (box_max_y),
    .target_found (target_found),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in a burst.
  function automatic int pick_gap(bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pixel as {blue, green, red}. Most pixels lean hard toward the tested
  // channel so that runs build up; the rest are noise and the two extremes.
  function automatic logic [3*PIX_W-1:0] pick_pixel(logic [1:0] chan_sel);
    int               roll;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo_a;
    logic [PIX_W-1:0] lo_b;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 6) return '1;
    if (roll < 18) return (3*PIX_W)'($urandom);
    hi   = PIX_W'($urandom_range(120, 255));
    lo_a = ($urandom_range(0, 2) == 0) ? '0 : PIX_W'($urandom_range(0, 40));
    lo_b = ($urandom_range(0, 2) == 0) ? '0 : PIX_W'($urandom_range(0, 40));
    case (chan_sel)
      CH_BLUE:  return {hi, lo_a, lo_b};
      CH_GREEN: return {lo_a, hi, lo_b};
      default:  return {lo_a, lo_b, hi};
    endcase
  endfunction

  // Offer one pixel word after a random gap; hold it until full drops at
  // an edge. Push is only lowered when a gap follows, so a back to back
  // word keeps it high.
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r, input logic eol, input logic eof);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    blue         <= b;
    green        <= g;
    red          <= r;
    end_of_line  <= eol;
    end_of_frame <= eof;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(b, g, r, eol, eof);
    pixels_sent++;
  endtask

  // Drop push and wait until every owed word has been popped, then let the
  // back part finish any division still running.
  task automatic settle();
    push <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable drops on the following cycle so that
  // back to back writes never assign it twice in one step.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrite a random subset of the registers, extremes included, and now and
  // then poke an index past the last register.
  task automatic shuffle_settings();
    logic [CFG_DATA_W-1:0] value;
    int unsigned           pick;
    int                    roll;
    for (int i = REG_CHANNEL_SELECT; i <= REG_MARK_ENABLE; i++) begin
      if ($urandom_range(0, 4) < 2) continue;
      roll = $urandom_range(0, 19);
      case (CFG_INDEX_W'(i))
        REG_CHANNEL_SELECT:   pick = $urandom_range(0, 3);
        REG_RATIO_THRESHOLD:  pick = (roll < 2) ? 0 : (roll < 4) ? 256 :
                                     (roll == 4) ? $urandom_range(257, 511) :
                                     $urandom_range(40, 192);
        REG_ABSOLUTE_MINIMUM: pick = (roll < 3) ? 0 : (roll == 3) ? 765 :
                                     (roll == 4) ? 1023 : $urandom_range(1, 160);
        REG_MINIMUM_RUN:      pick = (roll < 4) ? 0 : (roll == 4) ? 1023 :
                                     $urandom_range(1, 6);
        REG_MINIMUM_COUNT:    pick = (roll < 2) ? 32'(COUNT_MAX) :
                                     (roll < 4) ? $urandom :
                                     $urandom_range(0, 24);
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT:     pick = (roll < 2) ? 1 : (roll < 4) ? 4096 :
                                     (roll == 4) ? $urandom_range(0, 8191) :
                                     $urandom_range(1, 4096);
        default:              pick = $urandom_range(0, 1);
      endcase
      value = CFG_DATA_W'(pick);
      // stray upper bits must be masked by the block
      if ($urandom_range(0, 7) == 0) value = CFG_DATA_W'($urandom);
      cfg_write(CFG_INDEX_W'(i), value);
    end
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_INDEX_W'(REG_MARK_ENABLE + 1 + $urandom_range(0, 7)),
                CFG_DATA_W'($urandom));
  endtask

  // One frame in raster order. A clean frame marks each row end (the last one
  // only at random) and closes on the last pixel; a noisy one scatters the marks and still closes.
  task automatic send_frame(input int cols, input int rows, input bit noisy);
    logic [3*PIX_W-1:0] px;
    logic               eol;
    logic               eof;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        px  = pick_pixel(sb.cfg.channel_select);
        eof = (y == rows - 1) && (x == cols - 1);
        if (noisy) begin
          eol = ($urandom_range(0, 7) == 0);
          eof = eof || ($urandom_range(0, 31) == 0);
        end else begin
          eol = eof ? logic'($urandom_range(0, 1)) : (x == cols - 1);
        end
        send_pixel(px[3*PIX_W-1 -: PIX_W], px[2*PIX_W-1 -: PIX_W], px[PIX_W-1:0], eol, eof);
      end
    end
  endtask

  // Receiver: pop words with random gaps, once holding off for a long
  // stretch on request, and check each accepted word against the oldest
  // owed one. Outputs are read right after the edge, so they hold the
  // values the block presented at that edge.
  initial begin : drain
    result_t got;
    int      gap;
    wait (!rst);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = pick_gap(rx_burst);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.marked       = marked;
      got.frame_done   = frame_done;
      got.centroid_x   = centroid_x;
      got.centroid_y   = centroid_y;
      got.pixel_count  = pixel_count;
      got.box_min_x    = box_min_x;
      got.box_max_x    = box_max_x;
      got.box_min_y    = box_min_y;
      got.box_max_y    = box_max_y;
      got.target_found = target_found;
      sb.check_word(got);
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(64'd8 * 64'd1_500_000);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int directed_pixels;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: run too short to count anything, so the frame reports
    // an empty blob with the reset box; the last pixel ends the frame
    // without an end-of-line mark.
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1);
    settle();

    // Everything qualifies: spare channel code tests red, zero thresholds
    // let even an all-zero pixel (channel sum of zero) through.
    cfg_write(REG_CHANNEL_SELECT, CFG_DATA_W'(CH_SPARE));
    cfg_write(REG_RATIO_THRESHOLD, 0);
    cfg_write(REG_ABSOLUTE_MINIMUM, 0);
    cfg_write(REG_MINIMUM_RUN, 0);
    cfg_write(REG_MINIMUM_COUNT, 0);
    cfg_write(REG_FRAME_WIDTH, 16);
    cfg_write(REG_FRAME_HEIGHT, 8);
    cfg_write(REG_MARK_ENABLE, 1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 1'b1);
    settle();

    // Ratio above one: nothing can pass, the box keeps the new frame size.
    cfg_write(REG_CHANNEL_SELECT, CFG_DATA_W'(CH_BLUE));
    cfg_write(REG_RATIO_THRESHOLD, 300);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
    settle();

    // Pure green at a full ratio and the channel minimum; a short run is
    // broken by one off-color pixel. Marking off, count never exceeds the
    // top threshold.
    cfg_write(REG_CHANNEL_SELECT, CFG_DATA_W'(CH_GREEN));
    cfg_write(REG_RATIO_THRESHOLD, 256);
    cfg_write(REG_ABSOLUTE_MINIMUM, 255);
    cfg_write(REG_MINIMUM_RUN, 2);
    cfg_write(REG_MINIMUM_COUNT, COUNT_MAX);
    cfg_write(REG_MARK_ENABLE, 0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_pixel(8'h01, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
    settle();
    directed_pixels = pixels_sent;

    // Random phases of small frames under shifting settings
    phase = 0;
    while (pixels_sent < directed_pixels + RANDOM_PIXELS) begin
      if (phase == 3) begin
        // One long pure-red run past the run counter ceiling, offered back
        // to back while the receiver stalls, so the queue fills and full
        // holds the sender off.
        cfg_write(REG_CHANNEL_SELECT, CFG_DATA_W'(CH_RED));
        cfg_write(REG_RATIO_THRESHOLD, 128);
        cfg_write(REG_ABSOLUTE_MINIMUM, 100);
        cfg_write(REG_MINIMUM_RUN, 5);
        cfg_write(REG_MARK_ENABLE, 1);
        hold_request = 1'b1;
        tx_burst     = 1'b1;
        for (int i = 0; i < LONG_RUN; i++)
          send_pixel(8'h00, 8'h00, 8'hFF, 1'b0, i == LONG_RUN - 1);
      end else begin
        shuffle_settings();
        repeat ($urandom_range(1, 4)) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          send_frame(($urandom_range(0, 5) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 48),
                     $urandom_range(1, 6), $urandom_range(0, 6) == 0);
        end
      end
      // pause the sender until every owed word is back
      settle();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
